// File: rtl/hlts_pkg.sv
// Package for the hashed LRU tile store: payload structs, sequencer states,
// sizing constants, function codes and the key-hash constants. No dependencies.
`default_nettype none
package hlts_pkg;
  localparam int MaxEntriesDef = 256;
  localparam int IndexSlotsDef = 512;
  localparam int SampleBitsDef = 64;

  localparam logic [2:0] FUNC_STORE = 3'd0;
  localparam logic [2:0] FUNC_TOUCH = 3'd1;
  localparam logic [2:0] FUNC_CLAIM = 3'd2;
  localparam logic [2:0] FUNC_QUERY = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  localparam logic [31:0] HashMulX = 32'h9E3779B1;
  localparam logic [31:0] HashMulZ = 32'h85EBCA77;
  localparam int HashShift = 15;

  typedef struct packed {
    logic [2:0]  func;
    logic signed [31:0] chunk_x;
    logic signed [31:0] chunk_z;
    logic [31:0] stamp;
    logic [31:0] serial;
    logic [63:0] sample_word;
  } in_req_t;

  typedef struct packed {
    logic        found;
    logic        changed;
    logic        stale;
    logic [7:0]  entry_index;
    logic [31:0] serial_out;
    logic        evicted;
    logic [8:0]  entry_count;
    logic [31:0] stored_total;
    logic [31:0] evicted_total;
    logic [31:0] drawn_total;
  } out_rsp_t;

  typedef enum logic [4:0] {
    ST_CLR,       // sweep index slots to empty
    ST_IDLE,
    ST_HX,        // hash multiply x
    ST_HZ,        // hash multiply z, combine
    ST_PRD,       // issue slot read
    ST_PCHK,      // slot data back
    ST_PKEY,      // entry key back
    ST_OP,        // apply operation for main lookup
    ST_SRD,       // neighbor lookup done; decide insert
    ST_LRD,       // LRU scan read
    ST_LCMP,
    ST_WR,        // write entry
    ST_RB,        // rebuild: read keys of entry
    ST_RBK,
    ST_IRD,       // insert probe read
    ST_ICHK,
    ST_RSP
  } state_t;
endpackage
`default_nettype wire

// File: rtl/hashed_lru_tile_store.sv
// Hashed LRU tile store, top level: APB register, sequencer, entry memories
// and linear-probing index. Uses hlts_pkg.
// A lookup hashes x then z, probes slots until a key match, an empty slot or a full
// pass, then applies the operation and responds; a store that changes data adds a
// neighbor lookup, a new key adds an insert, and when full an LRU scan and a rebuild.
// One request at a time; the result register holds until taken. Reset, capacity
// writes, clears and rebuilds sweep the index slots in use, one slot per cycle.
`default_nettype none
module hashed_lru_tile_store import hlts_pkg::*; #(
  parameter int MAX_ENTRIES = MaxEntriesDef,
  parameter int INDEX_SLOTS = IndexSlotsDef,
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_req_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_rsp_t         out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int EA = (EW < 1) ? 1 : EW;
  localparam int SW = $clog2(INDEX_SLOTS);
  localparam int SA = (SW < 1) ? 1 : SW;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int VW = CW;  // slot value: entry + 1
  localparam logic [8:0] CapMax = 9'(MAX_ENTRIES);

  // memories
  logic [31:0] kx_mem [MAX_ENTRIES];
  logic [31:0] kz_mem [MAX_ENTRIES];
  logic [31:0] use_mem [MAX_ENTRIES];
  logic [31:0] stp_mem [MAX_ENTRIES];
  logic [31:0] ser_mem [MAX_ENTRIES];
  logic [SAMPLE_BITS-1:0] smp_mem [MAX_ENTRIES];
  logic [VW-1:0] slot_mem [INDEX_SLOTS];

  state_t st_r, st_nxt;
  logic [8:0]  cap_r;
  logic [SA:0] smask_r;
  logic [CW-1:0] held_r, held_nxt;
  logic [31:0] tick_r, tick_nxt, stc_r, stc_nxt, evc_r, evc_nxt, drc_r, drc_nxt;
  in_req_t     req_r;
  out_rsp_t    rsp_r, rsp_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [31:0] hx_r, hx_nxt, lz_r, lz_nxt;
  logic [SA:0] ps_r, ps_nxt, pcnt_r, pcnt_nxt;
  logic        nbr_r, nbr_nxt;       // running neighbor lookup
  logic        hit_r, hit_nxt;
  logic [EA-1:0] hite_r, hite_nxt;
  logic [CW-1:0] ie_r, ie_nxt;       // scan / rebuild entry counter
  logic [EA-1:0] slot_r, slot_nxt, best_r, best_nxt;
  logic [31:0] bestu_r, bestu_nxt;
  logic        rb_r, rb_nxt;         // index insert in progress (rebuild or single insert)
  logic [SA:0] clr_r, clr_nxt;
  logic        mainf_r, mainf_nxt;

  // memory read ports (registered)
  logic [SA-1:0] srd_a;  logic [VW-1:0] srd_q;
  logic [EA-1:0] erd_a;  logic [31:0] kx_q, kz_q, use_q, stp_q, ser_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  // writes
  logic          sw_en;  logic [SA-1:0] sw_a; logic [VW-1:0] sw_d;
  logic          ew_en;  logic [EA-1:0] ew_a;
  logic          uw_en, tw_en, rw_en, mw_en;
  logic [31:0]   uw_d, tw_d;

  always_ff @(posedge clk) begin
    srd_q <= slot_mem[srd_a];
    if (sw_en) slot_mem[sw_a] <= sw_d;
  end
  always_ff @(posedge clk) begin
    kx_q <= kx_mem[erd_a]; kz_q <= kz_mem[erd_a]; use_q <= use_mem[erd_a];
    stp_q <= stp_mem[erd_a]; ser_q <= ser_mem[erd_a]; smp_q <= smp_mem[erd_a];
    if (ew_en) begin
      kx_mem[ew_a] <= req_r.chunk_x;
      kz_mem[ew_a] <= req_r.chunk_z;
    end
    if (uw_en) use_mem[ew_a] <= uw_d;
    if (tw_en) stp_mem[ew_a] <= tw_d;
    if (rw_en) ser_mem[ew_a] <= req_r.serial;
    if (mw_en) smp_mem[ew_a] <= req_r.sample_word[SAMPLE_BITS-1:0];
  end

  logic cfg_wr;
  logic [8:0] cap_in;
  logic [SA:0] smask_in;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == 1'b0);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {23'd0, cap_r} : 32'd0;

  always_comb begin
    logic [8:0] v;
    logic [SA:0] s;
    v = cfg_pwdata[8:0];
    if (v == 9'd0) v = 9'd1;
    if (v > CapMax) v = CapMax;
    cap_in = v;
    s = '0;
    for (int k = 0; k <= SA; k++)
      if ((INDEX_SLOTS >> k) != 0 && (1 << k) < 2 * int'(v)) s[k] = 1'b1;
    // mask = slot_count - 1; slot_count = min(pow2 >= 2v, INDEX_SLOTS)
    smask_in = s;
    if ((1 << SW) < INDEX_SLOTS) smask_in = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR; cap_r <= CapMax; clr_r <= '0; out_valid_r <= 1'b0;
      held_r <= '0; tick_r <= '0; stc_r <= '0; evc_r <= '0; drc_r <= '0;
      smask_r <= (SA + 1)'(INDEX_SLOTS - 1); rb_r <= 1'b0;
    end else if (cfg_wr) begin
      st_r <= ST_CLR; cap_r <= cap_in; smask_r <= smask_in; clr_r <= '0;
      held_r <= '0; tick_r <= '0; stc_r <= '0; evc_r <= '0; drc_r <= '0;
      out_valid_r <= out_valid_nxt; rb_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; out_valid_r <= out_valid_nxt;
      held_r <= held_nxt; tick_r <= tick_nxt;
      stc_r <= stc_nxt; evc_r <= evc_nxt; drc_r <= drc_nxt;
      rb_r <= rb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hx_r <= hx_nxt; lz_r <= lz_nxt; ps_r <= ps_nxt; pcnt_r <= pcnt_nxt;
    nbr_r <= nbr_nxt; hit_r <= hit_nxt; hite_r <= hite_nxt; ie_r <= ie_nxt;
    slot_r <= slot_nxt; best_r <= best_nxt; bestu_r <= bestu_nxt;
    mainf_r <= mainf_nxt; rsp_r <= rsp_nxt;
    if (in_valid && in_ready) req_r <= in_data;
  end

  assign in_ready  = (st_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = rsp_r;

  logic [31:0] mulv;
  logic [31:0] hsum;
  logic [SA:0] slot_cnt;
  assign slot_cnt = smask_r + 1'b1;

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; out_valid_nxt = out_valid_r;
    held_nxt = held_r; tick_nxt = tick_r;
    stc_nxt = stc_r; evc_nxt = evc_r; drc_nxt = drc_r;
    hx_nxt = hx_r; lz_nxt = lz_r; ps_nxt = ps_r; pcnt_nxt = pcnt_r;
    nbr_nxt = nbr_r; hit_nxt = hit_r; hite_nxt = hite_r; ie_nxt = ie_r;
    slot_nxt = slot_r; best_nxt = best_r; bestu_nxt = bestu_r; rb_nxt = rb_r;
    mainf_nxt = mainf_r; rsp_nxt = rsp_r;
    srd_a = ps_r[SA-1:0]; erd_a = hite_r;
    sw_en = 1'b0; sw_a = ps_r[SA-1:0]; sw_d = '0;
    ew_en = 1'b0; ew_a = slot_r; uw_en = 1'b0; tw_en = 1'b0; rw_en = 1'b0;
    mw_en = 1'b0; uw_d = tick_r + 32'd1; tw_d = 32'd0;
    mulv = '0; hsum = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (st_r)
      ST_CLR: begin
        sw_en = 1'b1; sw_a = clr_r[SA-1:0]; sw_d = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r[SA-1:0] == smask_r[SA-1:0] || SW == 0) begin
          clr_nxt = '0;
          st_nxt = rb_r ? ST_RB : ST_IDLE;
          ie_nxt = '0;
        end
      end
      ST_IDLE: begin
        rb_nxt = 1'b0;
        if (in_valid && in_ready) begin
          nbr_nxt = 1'b0;
          lz_nxt = in_data.chunk_z;
          rsp_nxt = '0;
          if (in_data.func <= FUNC_QUERY) st_nxt = ST_HX;
          else begin
            if (in_data.func == FUNC_CLEAR) begin
              // sweep, then an empty rebuild hands off to the response
              held_nxt = '0; tick_nxt = '0; drc_nxt = '0;
              rb_nxt = 1'b1; st_nxt = ST_CLR;
            end else st_nxt = ST_RSP;
          end
        end
      end
      // shared multiplier: x then z
      ST_HX: begin
        mulv = (rb_r ? kx_q : req_r.chunk_x) * HashMulX;
        hx_nxt = mulv; st_nxt = ST_HZ;
      end
      ST_HZ: begin
        mulv = lz_r * HashMulZ;
        hsum = hx_r ^ mulv;
        hsum = hsum ^ (hsum >> HashShift);
        ps_nxt = hsum[SA:0] & smask_r;
        pcnt_nxt = '0;
        st_nxt = rb_r ? ST_IRD : ST_PRD;
      end
      ST_PRD: st_nxt = ST_PCHK;
      ST_PCHK: begin
        hite_nxt = EA'(srd_q - 1'b1);
        erd_a = EA'(srd_q - 1'b1);
        if (srd_q == '0) begin hit_nxt = 1'b0; st_nxt = nbr_r ? ST_SRD : ST_OP; end
        else if (CW'(srd_q - 1'b1) < held_r) st_nxt = ST_PKEY;
        else st_nxt = ST_PKEY;
      end
      ST_PKEY: begin
        if (CW'(srd_q - 1'b1) < held_r && kx_q == req_r.chunk_x && kz_q == lz_r) begin
          hit_nxt = 1'b1; st_nxt = nbr_r ? ST_SRD : ST_OP;
        end else if (pcnt_r + 1'b1 == slot_cnt) begin
          hit_nxt = 1'b0; st_nxt = nbr_r ? ST_SRD : ST_OP;
        end else begin
          ps_nxt = (ps_r + 1'b1) & smask_r; pcnt_nxt = pcnt_r + 1'b1;
          st_nxt = ST_PRD;
        end
      end
      ST_OP: begin
        // hite_r entry data is on the read port
        mainf_nxt = hit_r;
        rsp_nxt.found = hit_r;
        rsp_nxt.entry_index = hit_r ? 8'(hite_r) : 8'd0;
        rsp_nxt.serial_out = hit_r ? ser_q : 32'd0;
        ew_a = hite_r; slot_nxt = hite_r;
        st_nxt = ST_RSP;
        unique case (req_r.func)
          FUNC_STORE: begin
            if (hit_r) begin
              uw_en = 1'b1; rw_en = 1'b1; tick_nxt = tick_r + 32'd1;
              rsp_nxt.serial_out = req_r.serial;
              if (smp_q != req_r.sample_word[SAMPLE_BITS-1:0]) begin
                mw_en = 1'b1; tw_en = 1'b1; stc_nxt = stc_r + 32'd1;
                rsp_nxt.changed = 1'b1;
                nbr_nxt = 1'b1; lz_nxt = req_r.chunk_z + 32'd1; st_nxt = ST_HX;
              end
            end else begin
              stc_nxt = stc_r + 32'd1; rsp_nxt.changed = 1'b1;
              nbr_nxt = 1'b1; lz_nxt = req_r.chunk_z + 32'd1; st_nxt = ST_HX;
            end
          end
          FUNC_TOUCH: if (hit_r) begin uw_en = 1'b1; tick_nxt = tick_r + 32'd1; end
          FUNC_CLAIM: if (hit_r) begin
            tw_en = 1'b1; tw_d = req_r.stamp; drc_nxt = drc_r + 32'd1;
          end
          default: rsp_nxt.stale = hit_r && (stp_q != req_r.stamp);
        endcase
      end
      ST_SRD: begin
        // neighbor stamp cleared, then insert if key was absent
        if (hit_r) begin ew_a = hite_r; tw_en = 1'b1; end
        lz_nxt = req_r.chunk_z;
        if (mainf_r) st_nxt = ST_RSP;
        else if (held_r < CW'(cap_r)) begin
          slot_nxt = EA'(held_r); held_nxt = held_r + 1'b1;
          st_nxt = ST_WR;
        end else begin
          ie_nxt = CW'(1); best_nxt = '0; erd_a = '0; st_nxt = ST_LRD;
          rsp_nxt.evicted = 1'b1; evc_nxt = evc_r + 32'd1;
        end
      end
      ST_LRD: begin
        erd_a = EA'(ie_r - 1'b1); st_nxt = ST_LCMP;
      end
      ST_LCMP: begin
        // use_q belongs to entry ie_r-1
        if (ie_r == CW'(1) || use_q < bestu_r) begin
          bestu_nxt = use_q; best_nxt = EA'(ie_r - 1'b1);
        end
        if (ie_r == held_r) begin
          st_nxt = ST_WR;
          slot_nxt = (ie_r == CW'(1) || use_q < bestu_r) ? EA'(ie_r - 1'b1) : best_r;
        end else begin
          ie_nxt = ie_r + 1'b1; st_nxt = ST_LRD;
        end
      end
      ST_WR: begin
        ew_en = 1'b1; uw_en = 1'b1; tw_en = 1'b1; rw_en = 1'b1; mw_en = 1'b1;
        tick_nxt = tick_r + 32'd1;
        rsp_nxt.entry_index = 8'(slot_r); rsp_nxt.serial_out = req_r.serial;
        if (rsp_r.evicted) begin rb_nxt = 1'b1; clr_nxt = '0; st_nxt = ST_CLR; end
        else begin rb_nxt = 1'b1; ie_nxt = CW'(slot_r); st_nxt = ST_RB; end
        mainf_nxt = rsp_r.evicted;  // rebuild all vs. single insert
      end
      ST_RB: begin
        if (ie_r >= held_r || (!mainf_r && ie_r != CW'(slot_r))) begin
          rb_nxt = 1'b0; st_nxt = ST_RSP;
        end else begin
          erd_a = EA'(ie_r); st_nxt = ST_RBK;
        end
      end
      ST_RBK: begin
        lz_nxt = kz_q; erd_a = EA'(ie_r); st_nxt = ST_HX;
      end
      ST_IRD: st_nxt = ST_ICHK;
      ST_ICHK: begin
        if (srd_q == '0 || pcnt_r + 1'b1 == slot_cnt) begin
          if (srd_q == '0) begin sw_en = 1'b1; sw_d = VW'(ie_r + 1'b1); end
          ie_nxt = ie_r + 1'b1; st_nxt = ST_RB;
          if (!mainf_r) begin rb_nxt = 1'b0; st_nxt = ST_RSP; end
        end else begin
          ps_nxt = (ps_r + 1'b1) & smask_r; pcnt_nxt = pcnt_r + 1'b1;
          st_nxt = ST_IRD;
        end
      end
      ST_RSP: begin
        rsp_nxt.entry_count = 9'(held_r);
        rsp_nxt.stored_total = stc_r; rsp_nxt.evicted_total = evc_r;
        rsp_nxt.drawn_total = drc_r;
        out_valid_nxt = 1'b1; rb_nxt = 1'b0; st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (st_r == ST_HX && rb_r) erd_a = EA'(ie_r);
  end
endmodule
`default_nettype wire
